[hw/rtl/rvss_pkg.sv]
package rvss_pkg;

    localparam int MEM_AW   = 16;
    localparam int MEM_BYTES = 1 << MEM_AW;
    localparam int ROWS     = MEM_BYTES / 4;
    localparam int ROW_W    = MEM_AW - 2;
    localparam int NUM_REGS = 32;
    localparam int REG_AW   = $clog2(NUM_REGS);

    localparam logic [31:0] PC_RESET = 32'h0000_1000;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] F7_ADD    = 7'h00;
    localparam logic [6:0] F7_SUB    = 7'h20;
    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BEQ    = 3'd0;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_EXEC = 2'd1,
        CMD_RREG = 2'd2,
        CMD_RMEM = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_EXEC,
        ST_LOAD
    } st_t;

    typedef logic [3:0][ROW_W-1:0] rows_t;
    typedef logic [3:0][7:0]       lanes_t;

    typedef struct packed {
        logic       rd_en;
        rows_t      rd_row;
        logic [3:0] wr_en;
        rows_t      wr_row;
        lanes_t     wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              ra_en;
        logic [REG_AW-1:0] ra;
        logic              rb_en;
        logic [REG_AW-1:0] rb;
        logic              we;
        logic [REG_AW-1:0] wa;
        logic [31:0]       wd;
    } rf_req_t;

    typedef struct packed {
        logic [31:0] pc_now;
        logic        reg_write_done;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        store_done;
        logic [15:0] store_address;
        logic [31:0] store_word;
        logic        branch_taken;
        logic        unknown_opcode;
        logic [31:0] read_value;
    } res_t;

    // row of each bank for a word starting at addr; lanes below the start wrap to the next row
    function automatic rows_t word_rows(input logic [MEM_AW-1:0] addr);
        rows_t             rows;
        logic [ROW_W-1:0]  r;
        r = addr[MEM_AW-1:2];
        for (int k = 0; k < 4; k++) begin
            rows[k] = (2'(k) >= addr[1:0]) ? r : r + ROW_W'(1);
        end
        return rows;
    endfunction

    function automatic logic [31:0] lane_word(input lanes_t q, input logic [1:0] l);
        lanes_t wb;
        for (int i = 0; i < 4; i++) begin
            wb[i] = q[2'(l + 2'(i))];
        end
        return wb;
    endfunction

    function automatic lanes_t word_lanes(input logic [31:0] w, input logic [1:0] l);
        lanes_t d;
        lanes_t wb;
        wb = w;
        for (int k = 0; k < 4; k++) begin
            d[k] = wb[2'(2'(k) - l)];
        end
        return d;
    endfunction

endpackage

[hw/rtl/rv32_subset_core_step.sv]
// channel | direction | handshake          | payload
// in      | into core | in_valid/in_stall   | opcode, byte_address, byte_value, reg_select
// out     | from core | out_valid/out_stall | pc_now ... read_value (one result per item)
//
// Steps per item: IDLE then RD; an instruction adds EXEC, and LW adds LOAD after it.
// Each step after IDLE, but for a byte load, waits on one registered read: the lane banks
// (fetch, byte read, LW data) or the register file (operands, register read).
// Reset: the byte banks are swept to zero, one row per cycle, over all 16384 rows
// (MEM_BYTES/4); one item may be taken into the input register meanwhile.
// Stalls: an input register and an output register let the next item in while a
// result waits on out_stall.
module rv32_subset_core_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] byte_address,
    input  logic [7:0]  byte_value,
    input  logic [4:0]  reg_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pc_now,
    output logic        reg_write_done,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        store_done,
    output logic [15:0] store_address,
    output logic [31:0] store_word,
    output logic        branch_taken,
    output logic        unknown_opcode,
    output logic [31:0] read_value
);

    localparam int AW = rvss_pkg::MEM_AW;
    localparam int RW = rvss_pkg::ROW_W;

    rvss_pkg::st_t     state_reg, state_next;
    rvss_pkg::cmd_t    hold_cmd_reg;
    logic [15:0]       hold_addr_reg;
    logic [7:0]        hold_byte_reg;
    logic [4:0]        hold_rsel_reg;
    logic              hold_full_reg, hold_full_next;
    rvss_pkg::cmd_t    cur_cmd_reg, cmd_next;
    logic [1:0]        lane_reg, lane_next;
    logic [31:0]       ir_reg, ir_next;
    logic [31:0]       pc_reg, pc_next;
    logic [RW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    rvss_pkg::res_t    out_res_reg;

    rvss_pkg::mem_req_t mreq;
    rvss_pkg::lanes_t   mem_q;
    rvss_pkg::rf_req_t  rfq;
    rvss_pkg::res_t     res;
    logic [31:0]        rf_a, rf_b;

    logic        hold_accept, pop, fin, out_free;
    logic [31:0] npc;
    logic [31:0] fetched;
    logic [AW-1:0] hold_addr_m, pc_m, ea_m;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_i, imm_s, imm_b, ea_sum, alu;
    logic        is_lw, alu_ok;

    rvss_mem u_mem (
        .clk (clk),
        .req (mreq),
        .q   (mem_q)
    );

    rvss_rf u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rfq),
        .a     (rf_a),
        .b     (rf_b)
    );

    assign out_free    = !out_valid_reg || !out_stall;
    assign pop         = (state_reg == rvss_pkg::ST_IDLE) && hold_full_reg;
    assign in_stall    = hold_full_reg && !pop;
    assign hold_accept = in_valid && !in_stall;

    assign hold_addr_m = AW'(32'(hold_addr_reg));
    assign pc_m        = pc_reg[AW-1:0];
    assign fetched     = rvss_pkg::lane_word(mem_q, lane_reg);

    assign op    = ir_reg[6:0];
    assign rd    = ir_reg[11:7];
    assign f3    = ir_reg[14:12];
    assign f7    = ir_reg[31:25];
    assign imm_i = {{20{ir_reg[31]}}, ir_reg[31:20]};
    assign imm_s = {{20{ir_reg[31]}}, ir_reg[31:25], ir_reg[11:7]};
    assign imm_b = {{19{ir_reg[31]}}, ir_reg[31], ir_reg[7], ir_reg[30:25],
                    ir_reg[11:8], 1'b0};
    assign ea_sum = rf_a + ((op == rvss_pkg::OP_STORE) ? imm_s : imm_i);
    assign ea_m   = ea_sum[AW-1:0];
    assign alu    = (f7 == rvss_pkg::F7_SUB) ? rf_a - rf_b : rf_a + rf_b;
    assign alu_ok = (f3 == rvss_pkg::F3_ADD)
                    && ((f7 == rvss_pkg::F7_ADD) || (f7 == rvss_pkg::F7_SUB));
    assign is_lw  = (op == rvss_pkg::OP_LOAD) && (f3 == rvss_pkg::F3_WORD);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rvss_pkg::ST_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = rvss_pkg::ST_IDLE;
                end
            end
            rvss_pkg::ST_IDLE:
            begin
                if (hold_full_reg)
                begin
                    state_next = rvss_pkg::ST_RD;
                end
            end
            rvss_pkg::ST_RD:
            begin
                if (cur_cmd_reg == rvss_pkg::CMD_EXEC)
                begin
                    state_next = rvss_pkg::ST_EXEC;
                end
                else if (out_free)
                begin
                    state_next = rvss_pkg::ST_IDLE;
                end
            end
            rvss_pkg::ST_EXEC:
            begin
                if (is_lw)
                begin
                    state_next = rvss_pkg::ST_LOAD;
                end
                else if (out_free)
                begin
                    state_next = rvss_pkg::ST_IDLE;
                end
            end
            rvss_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = rvss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rvss_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control and result
    always_comb
    begin
        mreq      = '0;
        rfq       = '0;
        res       = '0;
        npc       = pc_reg;
        fin       = 1'b0;
        lane_next = lane_reg;
        ir_next   = ir_reg;
        cmd_next  = cur_cmd_reg;
        case (state_reg)
            rvss_pkg::ST_CLEAR:
            begin
                mreq.wr_en  = '1;
                mreq.wr_row = {4{clr_cnt_reg}};
            end
            rvss_pkg::ST_IDLE:
            begin
                if (hold_full_reg)
                begin
                    cmd_next = hold_cmd_reg;
                    case (hold_cmd_reg)
                        rvss_pkg::CMD_LOAD:
                        begin
                            mreq.wr_en[hold_addr_m[1:0]] = 1'b1;
                            mreq.wr_row  = rvss_pkg::word_rows(hold_addr_m);
                            mreq.wr_data = {4{hold_byte_reg}};
                        end
                        rvss_pkg::CMD_EXEC:
                        begin
                            mreq.rd_en  = 1'b1;
                            mreq.rd_row = rvss_pkg::word_rows(pc_m);
                            lane_next   = pc_m[1:0];
                        end
                        rvss_pkg::CMD_RREG:
                        begin
                            rfq.ra_en = 1'b1;
                            rfq.ra    = hold_rsel_reg;
                        end
                        rvss_pkg::CMD_RMEM:
                        begin
                            mreq.rd_en  = 1'b1;
                            mreq.rd_row = rvss_pkg::word_rows(hold_addr_m);
                            lane_next   = hold_addr_m[1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rvss_pkg::ST_RD:
            begin
                case (cur_cmd_reg)
                    rvss_pkg::CMD_EXEC:
                    begin
                        ir_next   = fetched;
                        rfq.ra_en = 1'b1;
                        rfq.ra    = fetched[19:15];
                        rfq.rb_en = 1'b1;
                        rfq.rb    = fetched[24:20];
                    end
                    rvss_pkg::CMD_RREG:
                    begin
                        res.read_value = rf_a;
                        fin            = out_free;
                    end
                    rvss_pkg::CMD_RMEM:
                    begin
                        res.read_value = 32'(mem_q[lane_reg]);
                        fin            = out_free;
                    end
                    default:
                    begin
                        fin = out_free;
                    end
                endcase
            end
            rvss_pkg::ST_EXEC:
            begin
                npc = pc_reg + 32'd4;
                case (op)
                    rvss_pkg::OP_REG:
                    begin
                        if (alu_ok && (rd != '0))
                        begin
                            res.reg_write_done = 1'b1;
                            res.dest_index     = rd;
                            res.dest_value     = alu;
                            rfq.we             = out_free;
                            rfq.wa             = rd;
                            rfq.wd             = alu;
                        end
                    end
                    rvss_pkg::OP_LOAD:
                    begin
                        if (is_lw)
                        begin
                            mreq.rd_en  = 1'b1;
                            mreq.rd_row = rvss_pkg::word_rows(ea_m);
                            lane_next   = ea_m[1:0];
                        end
                    end
                    rvss_pkg::OP_STORE:
                    begin
                        if (f3 == rvss_pkg::F3_WORD)
                        begin
                            res.store_done    = 1'b1;
                            res.store_address = 16'(32'(ea_m));
                            res.store_word    = rf_b;
                            mreq.wr_en        = {4{out_free}};
                            mreq.wr_row       = rvss_pkg::word_rows(ea_m);
                            mreq.wr_data      = rvss_pkg::word_lanes(rf_b, ea_m[1:0]);
                        end
                    end
                    rvss_pkg::OP_BRANCH:
                    begin
                        if ((f3 == rvss_pkg::F3_BEQ) && (rf_a == rf_b))
                        begin
                            npc              = pc_reg + imm_b;
                            res.branch_taken = 1'b1;
                        end
                    end
                    default:
                    begin
                        res.unknown_opcode = 1'b1;
                    end
                endcase
                fin = out_free && !is_lw;
            end
            rvss_pkg::ST_LOAD:
            begin
                npc = pc_reg + 32'd4;
                if (rd != '0)
                begin
                    res.reg_write_done = 1'b1;
                    res.dest_index     = rd;
                    res.dest_value     = fetched;
                    rfq.we             = out_free;
                    rfq.wa             = rd;
                    rfq.wd             = fetched;
                end
                fin = out_free;
            end
            default:
            begin
            end
        endcase
        res.pc_now = npc;
    end

    assign pc_next        = fin ? npc : pc_reg;
    assign clr_cnt_next   = (state_reg == rvss_pkg::ST_CLEAR) ? clr_cnt_reg + RW'(1)
                                                              : clr_cnt_reg;
    assign hold_full_next = hold_accept || (hold_full_reg && !pop);
    assign out_valid_next = fin || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rvss_pkg::ST_CLEAR;
            hold_full_reg <= 1'b0;
            cur_cmd_reg   <= rvss_pkg::CMD_LOAD;
            pc_reg        <= rvss_pkg::PC_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hold_full_reg <= hold_full_next;
            cur_cmd_reg   <= cmd_next;
            pc_reg        <= pc_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_accept)
        begin
            hold_cmd_reg  <= rvss_pkg::cmd_t'(opcode);
            hold_addr_reg <= byte_address;
            hold_byte_reg <= byte_value;
            hold_rsel_reg <= reg_select;
        end
        lane_reg <= lane_next;
        ir_reg   <= ir_next;
        if (fin)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pc_now         = out_res_reg.pc_now;
    assign reg_write_done = out_res_reg.reg_write_done;
    assign dest_index     = out_res_reg.dest_index;
    assign dest_value     = out_res_reg.dest_value;
    assign store_done     = out_res_reg.store_done;
    assign store_address  = out_res_reg.store_address;
    assign store_word     = out_res_reg.store_word;
    assign branch_taken   = out_res_reg.branch_taken;
    assign unknown_opcode = out_res_reg.unknown_opcode;
    assign read_value     = out_res_reg.read_value;

endmodule

[hw/rtl/rvss_mem.sv]
module rvss_mem (
    input  logic               clk,
    input  rvss_pkg::mem_req_t req,
    output rvss_pkg::lanes_t   q
);

    // four byte lanes, one per address bit pattern [1:0]
    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0] mem [rvss_pkg::ROWS];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (req.wr_en[k])
            begin
                mem[req.wr_row[k]] <= req.wr_data[k];
            end
            if (req.rd_en)
            begin
                q_reg <= mem[req.rd_row[k]];
            end
        end

        assign q[k] = q_reg;
    end

endmodule

[hw/rtl/rvss_rf.sv]
module rvss_rf (
    input  logic              clk,
    input  logic              rst_n,
    input  rvss_pkg::rf_req_t req,
    output logic [31:0]       a,
    output logic [31:0]       b
);

    logic [31:0]                   mem [rvss_pkg::NUM_REGS];
    logic [rvss_pkg::NUM_REGS-1:0] vld_reg;
    logic [rvss_pkg::NUM_REGS-1:0] vld_next;
    logic [31:0]                   qa_reg;
    logic [31:0]                   qb_reg;
    logic                          oka_reg;
    logic                          okb_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.wa] <= req.wd;
        end
        if (req.ra_en)
        begin
            qa_reg <= mem[req.ra];
        end
        if (req.rb_en)
        begin
            qb_reg <= mem[req.rb];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (req.we)
        begin
            vld_next[req.wa] = 1'b1;
        end
    end

    // never-written entries and x0 read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            oka_reg <= 1'b0;
            okb_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (req.ra_en)
            begin
                oka_reg <= (req.ra != '0) && vld_reg[req.ra];
            end
            if (req.rb_en)
            begin
                okb_reg <= (req.rb != '0) && vld_reg[req.rb];
            end
        end
    end

    assign a = oka_reg ? qa_reg : '0;
    assign b = okb_reg ? qb_reg : '0;

endmodule

[tb/rv32_subset_core_step_tb.sv]
`timescale 1ns / 1ps

module rv32_subset_core_step_tb;
    import rvss_pkg::*;

    localparam int RAND_ITEMS  = 920;
    localparam int HOLD_CYCLES = 64;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] addr;
        logic [7:0]  val;
        logic [4:0]  rsel;
        bit          typed;
        res_t        want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [15:0] byte_address = '0;
    logic [7:0]  byte_value = '0;
    logic [4:0]  reg_select = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] pc_now;
    logic        reg_write_done;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        store_done;
    logic [15:0] store_address;
    logic [31:0] store_word;
    logic        branch_taken;
    logic        unknown_opcode;
    logic [31:0] read_value;

    // shadow copy of the core state
    logic [31:0] pc_shadow;
    logic [31:0] regs_shadow [NUM_REGS];
    logic [7:0]  mem_shadow [MEM_BYTES];

    res_t        pending_steps[$];
    dir_row_t    dir_tab[$];
    int          err_cnt = 0;
    int          n_sent = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    rv32_subset_core_step i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .byte_address   (byte_address),
        .byte_value     (byte_value),
        .reg_select     (reg_select),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pc_now         (pc_now),
        .reg_write_done (reg_write_done),
        .dest_index     (dest_index),
        .dest_value     (dest_value),
        .store_done     (store_done),
        .store_address  (store_address),
        .store_word     (store_word),
        .branch_taken   (branch_taken),
        .unknown_opcode (unknown_opcode),
        .read_value     (read_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] reg_rd(input logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : regs_shadow[idx];
    endfunction

    // little-endian word, each byte address wraps at the end of memory
    function automatic logic [31:0] word_at(input logic [31:0] a);
        logic [31:0] w;
        for (int i = 0; i < 4; i++)
        begin
            w[8*i +: 8] = mem_shadow[16'(a + 32'(i))];
        end
        return w;
    endfunction

    task automatic step_core(input cmd_t c, input logic [15:0] a, input logic [7:0] v,
                             input logic [4:0] s, output res_t r);
        logic [31:0] ins;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] ea;
        logic [31:0] nxt;
        logic [31:0] wval;
        bit          wen;
        r    = '0;
        wen  = 1'b0;
        wval = '0;
        case (c)
            CMD_LOAD: mem_shadow[a] = v;
            CMD_RREG: r.read_value = reg_rd(s);
            CMD_RMEM: r.read_value = {24'h0, mem_shadow[a]};
            CMD_EXEC:
            begin
                ins = word_at(pc_shadow);
                opa = reg_rd(ins[19:15]);
                opb = reg_rd(ins[24:20]);
                nxt = pc_shadow + 32'd4;
                case (ins[6:0])
                    OP_REG:
                    begin
                        if (ins[14:12] == F3_ADD && ins[31:25] == F7_ADD)
                        begin
                            wval = opa + opb;
                            wen  = 1'b1;
                        end
                        else if (ins[14:12] == F3_ADD && ins[31:25] == F7_SUB)
                        begin
                            wval = opa - opb;
                            wen  = 1'b1;
                        end
                    end
                    OP_LOAD:
                    begin
                        if (ins[14:12] == F3_WORD)
                        begin
                            wval = word_at(opa + {{20{ins[31]}}, ins[31:20]});
                            wen  = 1'b1;
                        end
                    end
                    OP_STORE:
                    begin
                        if (ins[14:12] == F3_WORD)
                        begin
                            ea = opa + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                            for (int i = 0; i < 4; i++)
                            begin
                                mem_shadow[16'(ea + 32'(i))] = opb[8*i +: 8];
                            end
                            r.store_done    = 1'b1;
                            r.store_address = ea[15:0];
                            r.store_word    = opb;
                        end
                    end
                    OP_BRANCH:
                    begin
                        if (ins[14:12] == F3_BEQ && opa == opb)
                        begin
                            nxt = pc_shadow + {{19{ins[31]}}, ins[31], ins[7], ins[30:25],
                                               ins[11:8], 1'b0};
                            r.branch_taken = 1'b1;
                        end
                    end
                    default: r.unknown_opcode = 1'b1;
                endcase
                // x0 swallows the write
                if (wen && ins[11:7] != 5'd0)
                begin
                    regs_shadow[ins[11:7]] = wval;
                    r.reg_write_done = 1'b1;
                    r.dest_index     = ins[11:7];
                    r.dest_value     = wval;
                end
                pc_shadow = nxt;
            end
            default:
            begin
            end
        endcase
        r.pc_now = pc_shadow;
    endtask

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [6:0] op);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], op};
    endfunction

    // address reachable from x0 with a 12-bit signed offset
    function automatic logic [15:0] win_addr();
        logic s;
        s = 1'($urandom_range(1));
        return {{5{s}}, 11'($urandom)};
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [11:0] imm;
        logic [6:0]  op;
        int unsigned pick;
        rd   = 5'($urandom);
        rs1  = 5'($urandom);
        rs2  = 5'($urandom);
        imm  = 12'($urandom);
        pick = $urandom_range(99);
        if ($urandom_range(1) == 0)
        begin
            rs1 = 5'd0;
            imm = 12'(win_addr());
        end
        if (pick < 18)
            return enc_r(F7_ADD, rs2, rs1, F3_ADD, rd, OP_REG);
        if (pick < 34)
            return enc_r(F7_SUB, rs2, rs1, F3_ADD, rd, OP_REG);
        if (pick < 52)
            return enc_i(imm, rs1, F3_WORD, rd, OP_LOAD);
        if (pick < 66)
            return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OP_STORE};
        if (pick < 82)
        begin
            if ($urandom_range(1) == 0)
                rs2 = rs1;
            return enc_b({12'($urandom), 1'b0}, rs2, rs1, F3_BEQ, OP_BRANCH);
        end
        if (pick < 90)
        begin
            case ($urandom_range(3))
                0: op = OP_REG;
                1: op = OP_LOAD;
                2: op = OP_STORE;
                default: op = OP_BRANCH;
            endcase
            return {7'($urandom), rs2, rs1, 3'($urandom), rd, op};
        end
        if (pick < 96)
        begin
            op = 7'($urandom);
            while (op == OP_REG || op == OP_LOAD || op == OP_STORE || op == OP_BRANCH)
                op = 7'($urandom);
            return {25'($urandom), op};
        end
        return $urandom;
    endfunction

    function automatic dir_row_t dir_row(input cmd_t c, input logic [15:0] a,
                                         input logic [7:0] v, input logic [4:0] s,
                                         input bit typed, input logic [31:0] pc,
                                         input logic [31:0] rv, input logic unk);
        dir_row_t d;
        d.cmd  = c;
        d.addr = a;
        d.val  = v;
        d.rsel = s;
        d.typed = typed;
        d.want = '0;
        d.want.pc_now = pc;
        d.want.read_value = rv;
        d.want.unknown_opcode = unk;
        return d;
    endfunction

    // four byte loads of an instruction word, then execute it
    task automatic tab_word(input logic [15:0] a, input logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            dir_tab.push_back(dir_row(CMD_LOAD, a + 16'(i), w[8*i +: 8], 5'd0,
                                      1'b0, '0, '0, 1'b0));
        end
        dir_tab.push_back(dir_row(CMD_EXEC, 16'h0, 8'h0, 5'd0, 1'b0, '0, '0, 1'b0));
    endtask

    task automatic send_item(input cmd_t c, input logic [15:0] a, input logic [7:0] v,
                             input logic [4:0] s, input bit typed, input res_t want);
        res_t pred;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= c;
        byte_address <= a;
        byte_value   <= v;
        reg_select   <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_core(c, a, v, s, pred);
        pending_steps.push_back(typed ? want : pred);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_steps.size() != 0);
    endtask

    task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // receiver: random stall, long hold on request, check each accepted item
    initial
    begin
        res_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_steps.size() == 0)
                begin
                    $error("result with no item pending: pc_now %0h", pc_now);
                    err_cnt++;
                end
                else
                begin
                    e = pending_steps.pop_front();
                    cmp("pc_now", e.pc_now, pc_now);
                    cmp("reg_write_done", 32'(e.reg_write_done), 32'(reg_write_done));
                    cmp("dest_index", 32'(e.dest_index), 32'(dest_index));
                    cmp("dest_value", e.dest_value, dest_value);
                    cmp("store_done", 32'(e.store_done), 32'(store_done));
                    cmp("store_address", 32'(e.store_address), 32'(store_address));
                    cmp("store_word", e.store_word, store_word);
                    cmp("branch_taken", 32'(e.branch_taken), 32'(branch_taken));
                    cmp("unknown_opcode", 32'(e.unknown_opcode), 32'(unknown_opcode));
                    cmp("read_value", e.read_value, read_value);
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    initial
    begin
        logic [31:0] w;
        logic [15:0] base;
        int unsigned pick;
        int          n;
        int          n_dir;

        pc_shadow = PC_RESET;
        for (int i = 0; i < NUM_REGS; i++)
            regs_shadow[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++)
            mem_shadow[i] = '0;

        dir_tab.push_back(dir_row(CMD_RREG, 16'h0000, 8'h00, 5'd0, 1'b1,
                                  32'h1000, 32'h0, 1'b0));
        dir_tab.push_back(dir_row(CMD_RMEM, 16'hFFFF, 8'h00, 5'd0, 1'b1,
                                  32'h1000, 32'h0, 1'b0));
        // empty memory fetches opcode 0
        dir_tab.push_back(dir_row(CMD_EXEC, 16'h0000, 8'h00, 5'd0, 1'b1,
                                  32'h1004, 32'h0, 1'b1));
        dir_tab.push_back(dir_row(CMD_LOAD, 16'hFFFF, 8'hFF, 5'd31, 1'b1,
                                  32'h1004, 32'h0, 1'b0));
        dir_tab.push_back(dir_row(CMD_LOAD, 16'h0000, 8'hA5, 5'd0, 1'b1,
                                  32'h1004, 32'h0, 1'b0));
        dir_tab.push_back(dir_row(CMD_RMEM, 16'hFFFF, 8'h00, 5'd0, 1'b1,
                                  32'h1004, 32'hFF, 1'b0));
        // LW x31, -1(x0): word wraps around the end of memory
        tab_word(16'h1004, enc_i(12'hFFF, 5'd0, F3_WORD, 5'd31, OP_LOAD));
        // BEQ x0, x0 with the most negative offset
        tab_word(16'h1008, enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ, OP_BRANCH));
        // BEQ below zero: pc wraps to 0xFFFFFFFE, fetch straddles the memory end
        tab_word(16'h0008, enc_b(13'h1FF6, 5'd0, 5'd0, F3_BEQ, OP_BRANCH));
        // SUB into x0 is dropped
        tab_word(16'hFFFE, enc_r(F7_SUB, 5'd0, 5'd31, F3_ADD, 5'd0, OP_REG));
        dir_tab.push_back(dir_row(CMD_RREG, 16'h0000, 8'h00, 5'd31, 1'b0, '0, '0, 1'b0));
        n_dir = dir_tab.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
            send_item(dir_tab[k].cmd, dir_tab[k].addr, dir_tab[k].val, dir_tab[k].rsel,
                      dir_tab[k].typed, dir_tab[k].want);
        wait_drained();

        // phases: no idling, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++)
        begin
            snd_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 11 : 0;
            rcv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 11 : 0;
            if (ph % 2 == 0)
                hold_req = 1'b1;
            while (n_sent < n_dir + (ph + 1) * RAND_ITEMS / 4)
            begin
                pick = $urandom_range(99);
                if (pick < 55 || pick >= 94)
                begin
                    // full instruction at the pc, or a torn one
                    w = rand_instr();
                    n = (pick < 55) ? 4 : $urandom_range(3, 1);
                    for (int i = 0; i < n; i++)
                        send_item(CMD_LOAD, 16'(pc_shadow + 32'(i)), w[8*i +: 8],
                                  5'($urandom), 1'b0, '0);
                    send_item(CMD_EXEC, 16'($urandom), 8'($urandom), 5'($urandom),
                              1'b0, '0);
                end
                else if (pick < 70)
                begin
                    base = ($urandom_range(9) < 7) ? win_addr() : 16'($urandom);
                    for (int i = 0; i < 4; i++)
                        send_item(CMD_LOAD, base + 16'(i), 8'($urandom), 5'($urandom),
                                  1'b0, '0);
                end
                else if (pick < 80)
                    send_item(CMD_RREG, 16'($urandom), 8'($urandom), 5'($urandom),
                              1'b0, '0);
                else if (pick < 88)
                begin
                    base = ($urandom_range(1) == 0) ? win_addr() : 16'($urandom);
                    send_item(CMD_RMEM, base, 8'($urandom), 5'($urandom), 1'b0, '0);
                end
                else
                    send_item(CMD_EXEC, 16'($urandom), 8'($urandom), 5'($urandom),
                              1'b0, '0);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rvss_pkg.sv
hw/rtl/rvss_mem.sv
hw/rtl/rvss_rf.sv
hw/rtl/rv32_subset_core_step.sv
tb/rv32_subset_core_step_tb.sv
